// ===== rtl/edfs_pkg.sv =====
// Shared constants for the earliest-deadline-first batch job scheduler.
`default_nettype none

package edfs_pkg;

    // Default number of backlog slots.
    localparam int DEF_CAPACITY = 32;

    // Field widths of one item and one result.
    localparam int VAL_W   = 16;
    localparam int WANT_W  = 6;
    localparam int KIND_W  = 2;
    localparam int TOTAL_W = 21;
    localparam int SIZE_W  = 6;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 88;
    localparam int M_PAD_W   = M_TDATA_W - (3 * VAL_W + TOTAL_W + 2 * SIZE_W + 1);

    // Sort key: deadline, then compute, then id, most significant first.
    localparam int KEY_W = 3 * VAL_W;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXEC    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    // Input modes.
    localparam logic MODE_ADD     = 1'b0;
    localparam logic MODE_END_DAY = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/edf_batch_job_scheduler_top.sv =====
// Top level of the earliest-deadline-first batch job scheduler.
`default_nettype none

// The block holds a backlog of up to CAPACITY jobs in a memory with one write
// port and one registered read port, and works on one item at a time;
// s_axis_tready is high only while it is idle. An add item scans the valid
// bits one slot a cycle for a free slot (a full backlog is refused without a
// scan, with rejected set). An end-of-day item first sweeps every slot
// through the shared 48-bit comparator to drop expired jobs, then for each
// dispatched job sweeps the backlog again to find the smallest
// {deadline, compute, id} key, and closes with the summary. A finished
// result sits in the output register, so a slow consumer only stalls the
// sequencer when it tries to emit the next result. Job ids wrap from 65535
// to 0, the day counter starts at one and saturates at 65535, and the size
// and count fields carry the low six bits of the internal counters.
module edf_batch_job_scheduler_top #(
    parameter int CAPACITY = edfs_pkg::DEF_CAPACITY
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Input item: job_compute[15:0], job_deadline[31:16], dispatch_count[37:32].
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [edfs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: mode (0 add, 1 end of day).
    input  wire                            s_axis_tuser,
    // Result: job_id[15:0], out_compute[31:16], out_deadline[47:32],
    // total_compute[68:48], expired_count[74:69], backlog_size[80:75],
    // rejected[81].
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [edfs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: kind (0 acknowledge, 1 executed job, 2 day summary).
    output logic [edfs_pkg::KIND_W-1:0]    m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int VW  = edfs_pkg::VAL_W;
    localparam int KW  = edfs_pkg::KEY_W;
    localparam int TW  = edfs_pkg::TOTAL_W;
    localparam int SW  = edfs_pkg::SIZE_W;
    localparam int WW  = edfs_pkg::WANT_W;

    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
    localparam logic [VW-1:0] DAY_MAX  = {VW{1'b1}};

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_EXP  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_MIN  = 3'd4;
    localparam logic [2:0] S_PICK = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;

    // Control state.
    logic [2:0]          r_state, n_state;
    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [CW-1:0]       r_count, n_count;
    logic [VW-1:0]       r_next_id, n_next_id;
    logic [VW-1:0]       r_day, n_day;
    logic                r_issue, n_issue;
    logic                r_rd_en;
    logic                r_o_valid;
    logic                r_best_vld, n_best_vld;

    // Working registers.
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_rd_idx;
    logic [KW-1:0]       r_rd_key;
    logic [VW-1:0]       r_cmp, n_cmp;
    logic [VW-1:0]       r_dl, n_dl;
    logic [WW-1:0]       r_want, n_want;
    logic [WW-1:0]       r_sent, n_sent;
    logic [CW-1:0]       r_expired, n_expired;
    logic [TW-1:0]       r_total, n_total;
    logic [KW-1:0]       r_best_key, n_best_key;
    logic [IW-1:0]       r_best_idx, n_best_idx;

    // Output register.
    logic [edfs_pkg::KIND_W-1:0]  r_o_kind;
    logic [edfs_pkg::M_TDATA_W-1:0] r_o_data;
    logic                         r_o_last;

    // Backlog memory, one key per slot.
    logic [KW-1:0]       r_mem [CAPACITY];

    // Combinational signals.
    logic                w_accept;
    logic                w_out_free;
    logic                w_rd_last;
    logic                w_rd_hit;
    logic [KW-1:0]       w_cmp_a;
    logic [KW-1:0]       w_cmp_b;
    logic                w_lt;
    logic                w_mem_we;
    logic                w_emit;
    logic [edfs_pkg::KIND_W-1:0] w_kind;
    logic [VW-1:0]       w_id;
    logic [VW-1:0]       w_ocmp;
    logic [VW-1:0]       w_odl;
    logic [TW-1:0]       w_otot;
    logic [SW-1:0]       w_oexp;
    logic [SW-1:0]       w_osize;
    logic                w_orej;
    logic                w_olast;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_o_valid || m_axis_tready;
    assign w_rd_last     = r_rd_en && (r_rd_idx == LAST_IDX);
    assign w_rd_hit      = r_rd_en && r_valid[r_rd_idx];

    // The one shared comparator. In the expiry sweep it checks the slot's
    // deadline against the current day; in a dispatch sweep it checks the
    // slot's whole key against the best key found so far. A plain unsigned
    // compare of {deadline, compute, id} gives the dispatch order directly.
    always_comb begin
        if (r_state == S_EXP) begin
            w_cmp_a = {r_rd_key[KW-1 -: VW], {(KW - VW){1'b0}}};
            w_cmp_b = {r_day, {(KW - VW){1'b0}}};
        end else begin
            w_cmp_a = r_rd_key;
            w_cmp_b = r_best_key;
        end
    end
    assign w_lt = (w_cmp_a < w_cmp_b);

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_count    = r_count;
        n_next_id  = r_next_id;
        n_day      = r_day;
        n_issue    = r_issue;
        n_best_vld = r_best_vld;
        n_idx      = r_idx;
        n_cmp      = r_cmp;
        n_dl       = r_dl;
        n_want     = r_want;
        n_sent     = r_sent;
        n_expired  = r_expired;
        n_total    = r_total;
        n_best_key = r_best_key;
        n_best_idx = r_best_idx;

        w_mem_we = 1'b0;
        w_emit   = 1'b0;
        w_kind   = edfs_pkg::KIND_ACK;
        w_id     = '0;
        w_ocmp   = '0;
        w_odl    = '0;
        w_otot   = '0;
        w_oexp   = '0;
        w_osize  = SW'(r_count);
        w_orej   = 1'b0;
        w_olast  = 1'b0;

        // Sweep address generator: one slot a cycle, from 0 to the last.
        if (r_issue) begin
            if (r_idx == LAST_IDX) begin
                n_issue = 1'b0;
            end else begin
                n_idx = r_idx + IW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmp  = s_axis_tdata[VW-1:0];
                    n_dl   = s_axis_tdata[2*VW-1:VW];
                    n_want = s_axis_tdata[2*VW+WW-1:2*VW];
                    n_idx  = '0;
                    if (s_axis_tuser == edfs_pkg::MODE_ADD) begin
                        n_state = S_ADD;
                    end else begin
                        n_sent    = '0;
                        n_expired = '0;
                        n_total   = '0;
                        n_issue   = 1'b1;
                        n_state   = S_EXP;
                    end
                end
            end
            S_ADD: begin
                w_ocmp = r_cmp;
                w_odl  = r_dl;
                w_olast = 1'b1;
                if (r_count == FULL_CNT) begin
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        w_orej  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_valid[r_idx]) begin
                    n_idx = r_idx + IW'(1);
                end else if (w_out_free) begin
                    w_mem_we       = 1'b1;
                    n_valid[r_idx] = 1'b1;
                    n_count        = r_count + CW'(1);
                    n_next_id      = r_next_id + VW'(1);
                    w_emit         = 1'b1;
                    w_id           = r_next_id;
                    w_osize        = SW'(r_count + CW'(1));
                    n_state        = S_IDLE;
                end
            end
            S_EXP: begin
                if (w_rd_hit && w_lt) begin
                    n_valid[r_rd_idx] = 1'b0;
                    n_expired         = r_expired + CW'(1);
                    n_count           = r_count - CW'(1);
                end
                if (w_rd_last) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if ((r_sent == r_want) || (r_count == '0)) begin
                    n_state = S_SUM;
                end else begin
                    n_idx      = '0;
                    n_issue    = 1'b1;
                    n_best_vld = 1'b0;
                    n_state    = S_MIN;
                end
            end
            S_MIN: begin
                if (w_rd_hit && (!r_best_vld || w_lt)) begin
                    n_best_key = r_rd_key;
                    n_best_idx = r_rd_idx;
                    n_best_vld = 1'b1;
                end
                if (w_rd_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (w_out_free) begin
                    n_valid[r_best_idx] = 1'b0;
                    n_count  = r_count - CW'(1);
                    n_total  = r_total + TW'(r_best_key[KW-VW-1 -: VW]);
                    n_sent   = r_sent + WW'(1);
                    w_emit   = 1'b1;
                    w_kind   = edfs_pkg::KIND_EXEC;
                    w_id     = r_best_key[VW-1:0];
                    w_ocmp   = r_best_key[KW-VW-1 -: VW];
                    w_odl    = r_best_key[KW-1 -: VW];
                    w_osize  = SW'(r_count - CW'(1));
                    n_state  = S_CHK;
                end
            end
            S_SUM: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    w_kind  = edfs_pkg::KIND_SUMMARY;
                    w_otot  = r_total;
                    w_oexp  = SW'(r_expired);
                    w_olast = 1'b1;
                    if (r_day != DAY_MAX) begin
                        n_day = r_day + VW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_count    <= '0;
            r_next_id  <= VW'(1);
            r_day      <= VW'(1);
            r_issue    <= 1'b0;
            r_rd_en    <= 1'b0;
            r_best_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_count    <= n_count;
            r_next_id  <= n_next_id;
            r_day      <= n_day;
            r_issue    <= n_issue;
            r_rd_en    <= r_issue;
            r_best_vld <= n_best_vld;
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_rd_idx   <= r_idx;
        r_cmp      <= n_cmp;
        r_dl       <= n_dl;
        r_want     <= n_want;
        r_sent     <= n_sent;
        r_expired  <= n_expired;
        r_total    <= n_total;
        r_best_key <= n_best_key;
        r_best_idx <= n_best_idx;
        if (w_emit) begin
            r_o_kind <= w_kind;
            r_o_last <= w_olast;
            r_o_data <= {{edfs_pkg::M_PAD_W{1'b0}}, w_orej, w_osize, w_oexp, w_otot,
                         w_odl, w_ocmp, w_id};
        end
    end

    // Backlog memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_idx] <= {r_dl, r_cmp, r_next_id};
        end
        r_rd_key <= r_mem[r_idx];
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;

    // The fill count always matches the number of occupied slots.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("backlog count differs from occupied slots");

    // A job is only picked from an occupied slot found by a completed sweep.
    a_pick_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> (r_best_vld && r_valid[r_best_idx]))
        else $error("dispatch picked an empty slot");

    // The day counter starts at one and saturates, so it is never zero.
    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_day != '0)
        else $error("day counter reached zero");

    // Dispatch never sends more jobs than were asked for.
    a_sent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK || r_state == S_CHK || r_state == S_MIN)
        |-> (r_sent <= r_want))
        else $error("more jobs dispatched than requested");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the earliest-deadline-first batch job scheduler.
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS          = edfs_pkg::DEF_CAPACITY;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int DRAIN_LIMIT    = 100_000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_OFF       = 600;
    localparam int RANDOM_ITEMS   = 220;

    // Field widths, taken from the package.
    localparam int KIND_W    = edfs_pkg::KIND_W;
    localparam int VAL_W     = edfs_pkg::VAL_W;
    localparam int TOTAL_W   = edfs_pkg::TOTAL_W;
    localparam int SIZE_W    = edfs_pkg::SIZE_W;
    localparam int WANT_W    = edfs_pkg::WANT_W;
    localparam int S_TDATA_W = edfs_pkg::S_TDATA_W;
    localparam int M_TDATA_W = edfs_pkg::M_TDATA_W;
    localparam int M_PAD_W   = edfs_pkg::M_PAD_W;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    // One result as the scheduler should emit it.
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [VAL_W-1:0]   job_id;
        logic [VAL_W-1:0]   compute;
        logic [VAL_W-1:0]   deadline;
        logic [TOTAL_W-1:0] total;
        logic [SIZE_W-1:0]  expired;
        logic [SIZE_W-1:0]  size;
        logic               rejected;
        logic               last;
    } t_sched_result;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = edfs_pkg::MODE_ADD;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    // Scheduler state as predicted from the accepted items.
    logic [VAL_W-1:0]  slot_job_id   [SLOTS];
    logic [VAL_W-1:0]  slot_compute  [SLOTS];
    logic [VAL_W-1:0]  slot_deadline [SLOTS];
    bit                slot_used     [SLOTS];
    logic [SIZE_W-1:0] backlog_held = '0;
    logic [VAL_W-1:0]  next_job_id  = 16'd1;
    logic [VAL_W-1:0]  today        = 16'd1;

    t_sched_result pending_results[$];

    int       errors        = 0;
    int       items_sent    = 0;
    int       burst_left    = 0;
    bit       tx_idle_en    = 1'b0;
    t_rx_mode rx_mode       = RX_ALWAYS;
    int       rx_hold_cycles = 0;
    logic [7:0] rx_pattern  = 8'b1011_0110;

    edf_batch_job_scheduler_top #(
        .CAPACITY(SLOTS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    task automatic queue_result(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] id,
                                input logic [VAL_W-1:0] cmp, input logic [VAL_W-1:0] dl,
                                input logic [TOTAL_W-1:0] total,
                                input logic [SIZE_W-1:0] expired, input logic [SIZE_W-1:0] size,
                                input logic rejected, input logic last);
        t_sched_result r;
        r.kind     = kind;
        r.job_id   = id;
        r.compute  = cmp;
        r.deadline = dl;
        r.total    = total;
        r.expired  = expired;
        r.size     = size;
        r.rejected = rejected;
        r.last     = last;
        pending_results.push_back(r);
    endtask

    // Earliest deadline wins, then the smaller compute, then the lower id.
    function automatic bit goes_first(int a, int b);
        if (slot_deadline[a] != slot_deadline[b]) begin
            return slot_deadline[a] < slot_deadline[b];
        end
        if (slot_compute[a] != slot_compute[b]) begin
            return slot_compute[a] < slot_compute[b];
        end
        return slot_job_id[a] < slot_job_id[b];
    endfunction

    task automatic schedule_job_item(input logic mode, input logic [VAL_W-1:0] cmp,
                                     input logic [VAL_W-1:0] dl, input logic [WANT_W-1:0] want);
        int                 slot;
        int                 best;
        int                 sent;
        logic [SIZE_W-1:0]  expired;
        logic [TOTAL_W-1:0] total;
        if (mode == edfs_pkg::MODE_ADD) begin
            slot = 0;
            while (slot < SLOTS && slot_used[slot]) slot++;
            if (slot == SLOTS) begin
                // A full backlog refuses the job and keeps the id for the next one.
                queue_result(edfs_pkg::KIND_ACK, '0, cmp, dl, '0, '0, backlog_held, 1'b1, 1'b1);
            end else begin
                slot_used[slot]     = 1'b1;
                slot_job_id[slot]   = next_job_id;
                slot_compute[slot]  = cmp;
                slot_deadline[slot] = dl;
                backlog_held++;
                queue_result(edfs_pkg::KIND_ACK, next_job_id, cmp, dl, '0, '0, backlog_held,
                             1'b0, 1'b1);
                next_job_id++;
            end
        end else begin
            expired = '0;
            total   = '0;
            for (slot = 0; slot < SLOTS; slot++) begin
                if (slot_used[slot] && slot_deadline[slot] < today) begin
                    slot_used[slot] = 1'b0;
                    expired++;
                    backlog_held--;
                end
            end
            for (sent = 0; sent < want && backlog_held > 0; sent++) begin
                best = -1;
                for (slot = 0; slot < SLOTS; slot++) begin
                    if (slot_used[slot] && (best < 0 || goes_first(slot, best))) best = slot;
                end
                slot_used[best] = 1'b0;
                backlog_held--;
                total = total + TOTAL_W'(slot_compute[best]);
                queue_result(edfs_pkg::KIND_EXEC, slot_job_id[best], slot_compute[best],
                             slot_deadline[best], '0, '0, backlog_held, 1'b0, 1'b0);
            end
            queue_result(edfs_pkg::KIND_SUMMARY, '0, '0, '0, total, expired, backlog_held,
                         1'b0, 1'b1);
            if (today != 16'hFFFF) today++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of items separated by random gaps when idling is on.
    // ------------------------------------------------------------------

    task automatic send_item(input logic mode, input logic [VAL_W-1:0] cmp,
                             input logic [VAL_W-1:0] dl, input logic [WANT_W-1:0] want);
        int gap;
        if (tx_idle_en) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 6);
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left--;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, want, dl, cmp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        schedule_job_item(mode, cmp, dl, want);
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, plus a long hold-off on request.
    // ------------------------------------------------------------------

    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles - 1) @(negedge i_clk);
                rx_hold_cycles = 0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: begin
                        m_axis_tready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        m_axis_tready <= ($urandom_range(0, 99) < 65);
                    end
                    default: begin
                        rx_pattern    = {rx_pattern[6:0], rx_pattern[7]};
                        m_axis_tready <= rx_pattern[0];
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking: every accepted result against the oldest expectation.
    // ------------------------------------------------------------------

    task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        t_sched_result r;
        if (pending_results.size() == 0) begin
            $error("result with no item waiting for it: kind 0x%0h data 0x%0h",
                   m_axis_tuser, m_axis_tdata);
            errors++;
        end else begin
            r = pending_results.pop_front();
            check_field("kind",          32'(r.kind),     32'(m_axis_tuser));
            check_field("job_id",        32'(r.job_id),   32'(m_axis_tdata[15:0]));
            check_field("out_compute",   32'(r.compute),  32'(m_axis_tdata[31:16]));
            check_field("out_deadline",  32'(r.deadline), 32'(m_axis_tdata[47:32]));
            check_field("total_compute", 32'(r.total),    32'(m_axis_tdata[68:48]));
            check_field("expired_count", 32'(r.expired),  32'(m_axis_tdata[74:69]));
            check_field("backlog_size",  32'(r.size),     32'(m_axis_tdata[80:75]));
            check_field("rejected",      32'(r.rejected), 32'(m_axis_tdata[81]));
            check_field("padding",       32'(0),
                        32'(m_axis_tdata[M_TDATA_W-1 -: M_PAD_W]));
            check_field("last",          32'(r.last),     32'(m_axis_tlast));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
    end

    // ------------------------------------------------------------------
    // Random field values
    // ------------------------------------------------------------------

    // Small values give plenty of ties on compute; the extremes come up often.
    function automatic logic [VAL_W-1:0] random_compute();
        case ($urandom_range(0, 3))
            0:       return VAL_W'($urandom_range(0, 3));
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Deadlines mostly fall close to the current day, so that some expire.
    function automatic logic [VAL_W-1:0] random_deadline();
        int d;
        if ($urandom_range(0, 7) == 0) return VAL_W'($urandom);
        d = int'(today) - 3 + int'($urandom_range(0, 10));
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        return d[VAL_W-1:0];
    endfunction

    function automatic logic [WANT_W-1:0] random_want();
        case ($urandom_range(0, 7))
            0:       return 6'd0;
            1, 2:    return 6'd32;
            default: return WANT_W'($urandom_range(1, 12));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, ties at each level of the ordering, expiry, and
    // dispatch requests larger than the backlog.
    task automatic test_directed_extremes();
        tx_idle_en = 1'b0;
        rx_mode    = RX_ALWAYS;
        send_item(edfs_pkg::MODE_END_DAY, 16'd0, 16'd0, 6'd0);
        send_item(edfs_pkg::MODE_ADD, 16'h0000, 16'h0000, 6'd0);
        send_item(edfs_pkg::MODE_ADD, 16'hFFFF, 16'hFFFF, 6'd31);
        send_item(edfs_pkg::MODE_ADD, 16'd7, 16'd5, 6'd32);
        send_item(edfs_pkg::MODE_ADD, 16'd7, 16'd5, 6'd0);
        send_item(edfs_pkg::MODE_ADD, 16'd3, 16'd5, 6'd0);
        send_item(edfs_pkg::MODE_ADD, 16'd9, 16'd2, 6'd0);
        // Day two: the deadline-zero job is dropped, the rest leave in order.
        send_item(edfs_pkg::MODE_END_DAY, 16'hFFFF, 16'hFFFF, 6'd31);
        send_item(edfs_pkg::MODE_ADD, 16'd2, 16'd3, 6'd0);
        send_item(edfs_pkg::MODE_ADD, 16'd1, 16'd3, 6'd0);
        send_item(edfs_pkg::MODE_END_DAY, 16'd0, 16'd0, 6'd32);
        send_item(edfs_pkg::MODE_END_DAY, 16'd0, 16'd0, 6'd1);
        // Day five: one job expires while another is sent out.
        send_item(edfs_pkg::MODE_ADD, 16'd5, 16'd3, 6'd0);
        send_item(edfs_pkg::MODE_ADD, 16'd5, 16'd10, 6'd0);
        send_item(edfs_pkg::MODE_END_DAY, 16'd0, 16'd0, 6'd1);
        send_item(edfs_pkg::MODE_END_DAY, 16'd0, 16'd0, 6'd32);
    endtask

    // Runs of adds closed by an end of day, with overfilled backlogs and
    // some stray items mixed in, under changing idle patterns.
    task automatic test_random_traffic();
        int  stop_at;
        int  n;
        int  i;
        int  pick;
        bit  first_fill;
        bit  max_compute;
        stop_at    = items_sent + RANDOM_ITEMS;
        first_fill = 1'b1;
        while (items_sent < stop_at) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_mode    = t_rx_mode'($urandom_range(0, 2));
            pick       = first_fill ? 0 : $urandom_range(0, 9);
            if (pick == 0) begin
                // Fill the backlog, push a few more that must be refused,
                // then clear it; the first time every job costs the maximum.
                max_compute = first_fill;
                first_fill  = 1'b0;
                while (backlog_held < SLOTS) begin
                    send_item(edfs_pkg::MODE_ADD, max_compute ? 16'hFFFF : random_compute(),
                              max_compute ? 16'hFFFF : random_deadline(), 6'd0);
                end
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) send_item(edfs_pkg::MODE_ADD, random_compute(),
                                                  random_deadline(), random_want());
                send_item(edfs_pkg::MODE_END_DAY, 16'd0, 16'd0, 6'd32);
            end else if (pick == 1) begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    send_item($urandom_range(0, 1) ? edfs_pkg::MODE_END_DAY : edfs_pkg::MODE_ADD,
                              VAL_W'($urandom), VAL_W'($urandom),
                              WANT_W'($urandom_range(0, 32)));
                end
            end else begin
                n = $urandom_range(1, 12);
                for (i = 0; i < n; i++) send_item(edfs_pkg::MODE_ADD, random_compute(),
                                                  random_deadline(), 6'd0);
                send_item(edfs_pkg::MODE_END_DAY, VAL_W'($urandom), VAL_W'($urandom),
                          random_want());
            end
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the result register fills and the block stops taking input.
    task automatic test_output_backpressure();
        int i;
        tx_idle_en     = 1'b0;
        rx_mode        = RX_ALWAYS;
        rx_hold_cycles = HOLD_OFF;
        for (i = 0; i < 10; i++) send_item(edfs_pkg::MODE_ADD, random_compute(),
                                           today + 16'd3, 6'd0);
        send_item(edfs_pkg::MODE_END_DAY, 16'd0, 16'd0, 6'd10);
        send_item(edfs_pkg::MODE_END_DAY, 16'd0, 16'd0, 6'd32);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial begin
        int waited;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_random_traffic();
        test_output_backpressure();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard limit on the whole run.
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

endmodule
